// ----- design/ccp_pkg.sv -----
// shared types, constants and helpers of the capacity constrained path block
`timescale 1ns / 1ps

package ccp_pkg;

   // default sizes
   localparam int DEF_MAX_LAYERS   = 64;
   localparam int DEF_MAX_VALUES   = 4;
   localparam int DEF_MAX_CAPACITY = 15;

   // costs are signed Q32.16
   localparam int COST_W = 48;
   typedef logic signed [COST_W-1:0] cost_type;
   typedef logic signed [COST_W+1:0] cost_wide_type;
   localparam cost_type COST_MAX = {1'b0, {(COST_W-1){1'b1}}};
   localparam cost_type COST_MIN = {1'b1, {(COST_W-1){1'b0}}};

   // input commands
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_LAYER = 1'b1;

   // register map
   localparam int CSR_INDEX_W = 3;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CAPACITY,
      CSR_NUM_VALUES,
      CSR_BOUNDS_ACTIVE,
      CSR_LEFT_BOUND,
      CSR_RIGHT_BOUND,
      CSR_LEFT_WEIGHT,
      CSR_RIGHT_WEIGHT
   } csr_index_type;

   typedef struct packed {
      logic [3:0]         capacity;
      logic [2:0]         num_values;
      logic               bounds_active;
      logic signed [31:0] left_bound;
      logic signed [31:0] right_bound;
      logic signed [31:0] left_weight;
      logic signed [31:0] right_weight;
   } cfg_type;

   // engine sequencer
   typedef enum logic [3:0] {
      S_IDLE,
      S_FETCH_O,
      S_FETCH_P,
      S_CHECK,
      S_TERM,
      S_RD,
      S_WR,
      S_FIRST_WR,
      S_LAYER_END,
      S_OUT_FAIL,
      S_BT_RD,
      S_BT_WAIT,
      S_OUT_RD,
      S_OUT_PUT
   } eng_state_type;

   // term unit sequencer
   typedef enum logic [1:0] {
      T_IDLE,
      T_MUL,
      T_ACC
   } term_state_type;

   typedef enum logic [1:0] {
      SEL_G,
      SEL_W,
      SEL_L,
      SEL_R
   } term_sel_type;

   // engine to term unit
   typedef struct packed {
      logic start;
      logic first;
      logic add_left;
      logic add_right;
   } term_cmd_type;

   typedef struct packed {
      logic done;
   } term_sts_type;

   typedef struct packed {
      logic signed [31:0] g;
      logic signed [31:0] w;
      logic signed [16:0] d;
      logic [16:0]        dv;
      logic signed [15:0] v;
   } term_opnd_type;

   // sign extend a cost for addition
   function automatic cost_wide_type ext_cost(input cost_type c);
      return {{2{c[COST_W-1]}}, c};
   endfunction

   // saturate a grown sum back to the cost range
   function automatic cost_type sat_cost(input cost_wide_type v);
      if (v > ext_cost(COST_MAX)) return COST_MAX;
      if (v < ext_cost(COST_MIN)) return COST_MIN;
      return v[COST_W-1:0];
   endfunction

endpackage

// ----- design/ccp_ifs.sv -----
// channel interfaces of the capacity constrained path block
`timescale 1ns / 1ps

// input items
interface ccp_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic [1:0]         value_slot;
   logic signed [15:0] allowed_value;
   logic signed [31:0] gradient;
   logic signed [15:0] current_value;
   logic signed [31:0] switch_weight;
   logic               final_layer;

   modport source (output valid, cmd, value_slot, allowed_value, gradient, current_value,
                   switch_weight, final_layer, input ready);
   modport sink (input valid, cmd, value_slot, allowed_value, gradient, current_value,
                 switch_weight, final_layer, output ready);
endinterface

// result items
interface ccp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] chosen_value;
   logic               run_end;
   logic               infeasible;

   modport source (output valid, chosen_value, run_end, infeasible, input ready);
   modport sink (input valid, chosen_value, run_end, infeasible, output ready);
endinterface

// register writes
interface ccp_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  reg_index;
   logic [31:0] wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ----- design/ccp_csr.sv -----
// configuration registers of the capacity constrained path block
`timescale 1ns / 1ps

module ccp_csr (
   input  logic             clock,
   input  logic             reset,
   ccp_csr_if.sink          csr_chan,
   output ccp_pkg::cfg_type cfg
);
   import ccp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.reg_index))
            CSR_CAPACITY:      cfg_in.capacity      = csr_chan.wdata[3:0];
            CSR_NUM_VALUES:    cfg_in.num_values    = csr_chan.wdata[2:0];
            CSR_BOUNDS_ACTIVE: cfg_in.bounds_active = csr_chan.wdata[0];
            CSR_LEFT_BOUND:    cfg_in.left_bound    = csr_chan.wdata;
            CSR_RIGHT_BOUND:   cfg_in.right_bound   = csr_chan.wdata;
            CSR_LEFT_WEIGHT:   cfg_in.left_weight   = csr_chan.wdata;
            CSR_RIGHT_WEIGHT:  cfg_in.right_weight  = csr_chan.wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // reset values: capacity 15, two values, everything else zero
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{4'd15, 3'd2, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- design/ccp_term_unit.sv -----
// per slot pair cost term unit with one shared multiplier
`timescale 1ns / 1ps

module ccp_term_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  ccp_pkg::cfg_type       cfg,
   input  ccp_pkg::term_cmd_type  cmd,
   input  ccp_pkg::term_opnd_type opnd,
   output ccp_pkg::term_sts_type  sts,
   output ccp_pkg::cost_type      cost
);
   import ccp_pkg::*;

   localparam int MW = 33;
   localparam int PW = 2 * MW;

   term_state_type        state_ff, state_in;
   term_sel_type          sel_ff, sel_in;
   logic                  done_ff, done_in;
   logic signed [PW-1:0]  prod_ff, prod_in;
   logic                  neg_ff, neg_in;
   cost_type              acc_ff, acc_in;

   logic signed [MW-1:0]  op_a, op_b;
   logic signed [MW-1:0]  lw_abs, rw_abs;
   logic [31:0]           ldiff_abs, rdiff_abs;
   logic [63:0]           rnd;
   cost_type              bterm;
   logic                  finish;

   // |value * 2^16 - bound|, fits 32 bits
   function automatic logic [31:0] diff_abs(input logic signed [15:0] v,
                                            input logic signed [31:0] b);
      logic signed [33:0] dif;
      dif = {{2{v[15]}}, v, 16'b0} - {{2{b[31]}}, b};
      return dif[33] ? 32'(-dif) : dif[31:0];
   endfunction

   function automatic logic signed [MW-1:0] wabs(input logic signed [31:0] w);
      logic signed [MW-1:0] w33;
      w33 = {w[31], w};
      return w33[MW-1] ? -w33 : w33;
   endfunction

   assign lw_abs    = wabs(cfg.left_weight);
   assign rw_abs    = wabs(cfg.right_weight);
   assign ldiff_abs = diff_abs(opnd.v, cfg.left_bound);
   assign rdiff_abs = diff_abs(opnd.v, cfg.right_bound);

   // multiplier operand select
   always_comb begin
      case (sel_ff)
         SEL_G: begin
            op_a = {opnd.g[31], opnd.g};
            op_b = {{(MW-17){opnd.d[16]}}, opnd.d};
         end
         SEL_W: begin
            op_a = {opnd.w[31], opnd.w};
            op_b = {{(MW-17){1'b0}}, opnd.dv};
         end
         SEL_L: begin
            op_a = lw_abs;
            op_b = {1'b0, ldiff_abs};
         end
         default: begin
            op_a = rw_abs;
            op_b = {1'b0, rdiff_abs};
         end
      endcase
   end

   // rounded boundary term from the registered product
   assign rnd   = prod_ff[63:0] + 64'd32768;
   assign bterm = neg_ff ? -cost_type'(rnd[63:16]) : cost_type'(rnd[63:16]);

   // sequencer
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      done_in  = 1'b0;
      prod_in  = prod_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      finish   = 1'b0;
      unique case (state_ff)
         T_IDLE: begin
            if (cmd.start) begin
               sel_in   = SEL_G;
               state_in = T_MUL;
            end
         end
         T_MUL: begin
            prod_in  = op_a * op_b;
            neg_in   = (sel_ff == SEL_L) ? cfg.left_weight[31] : cfg.right_weight[31];
            state_in = T_ACC;
         end
         T_ACC: begin
            case (sel_ff)
               SEL_G: begin
                  acc_in = prod_ff[COST_W-1:0];
                  if (!cmd.first) sel_in = SEL_W;
                  else if (cmd.add_left) sel_in = SEL_L;
                  else if (cmd.add_right) sel_in = SEL_R;
                  else finish = 1'b1;
               end
               SEL_W: begin
                  acc_in = sat_cost(ext_cost(acc_ff) + ext_cost(prod_ff[COST_W-1:0]));
                  if (cmd.add_right) sel_in = SEL_R;
                  else finish = 1'b1;
               end
               SEL_L: begin
                  acc_in = sat_cost(ext_cost(acc_ff) + ext_cost(bterm));
                  if (cmd.add_right) sel_in = SEL_R;
                  else finish = 1'b1;
               end
               default: begin
                  acc_in = sat_cost(ext_cost(acc_ff) + ext_cost(bterm));
                  finish = 1'b1;
               end
            endcase
            if (finish) begin
               done_in  = 1'b1;
               state_in = T_IDLE;
            end else begin
               state_in = T_MUL;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff  <= sel_in;
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      acc_ff  <= acc_in;
   end

   assign sts.done = done_ff;
   assign cost     = acc_ff;

endmodule

// ----- design/ccp_engine.sv -----
// relaxation sequencer, cost rows, back pointers and backtrack
`timescale 1ns / 1ps

module ccp_engine #(
   parameter int MAX_LAYERS   = ccp_pkg::DEF_MAX_LAYERS,
   parameter int MAX_VALUES   = ccp_pkg::DEF_MAX_VALUES,
   parameter int MAX_CAPACITY = ccp_pkg::DEF_MAX_CAPACITY
) (
   input  logic                   clock,
   input  logic                   reset,
   ccp_req_if.sink                req_chan,
   ccp_rsp_if.source              rsp_chan,
   input  ccp_pkg::cfg_type       cfg,
   output ccp_pkg::term_cmd_type  term_cmd,
   output ccp_pkg::term_opnd_type term_opnd,
   input  ccp_pkg::term_sts_type  term_sts,
   input  ccp_pkg::cost_type      term_cost
);
   import ccp_pkg::*;

   localparam int SW        = $clog2(MAX_VALUES);
   localparam int CW        = $clog2(MAX_CAPACITY + 1);
   localparam int EW        = SW + CW;
   localparam int ROW_DEPTH = 1 << EW;
   localparam int LW        = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int BP_DEPTH  = 1 << (LW + EW);
   localparam int NVW       = $clog2(MAX_VALUES + 1);
   localparam logic [LW-1:0] LAST_LAYER = LW'(MAX_LAYERS - 1);

   eng_state_type        state_ff, state_in;
   logic [SW-1:0]        o_ff, o_in, p_ff, p_in;
   logic [CW-1:0]        u_ff, u_in;
   logic [LW-1:0]        k_ff, k_in, layer_ff, layer_in;
   logic                 bank_ff, bank_in, fin_ff, fin_in;
   logic signed [31:0]   g_ff, g_in, w_ff, w_in;
   logic signed [15:0]   x_ff, x_in, vo_ff, vo_in, v_ff, v_in;
   logic signed [16:0]   d_ff, d_in;
   logic [16:0]          dv_ff, dv_in;
   logic [EW-1:0]        e_ff, e_in;
   logic                 best_valid_ff, best_valid_in;
   cost_type             best_cost_ff, best_cost_in;
   logic [EW-1:0]        best_entry_ff, best_entry_in;
   logic [1:0][ROW_DEPTH-1:0] vld_ff;
   logic signed [15:0]   vtab_ff [MAX_VALUES];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]   rsp_value_ff, rsp_value_in;
   logic                 rsp_end_ff, rsp_end_in, rsp_inf_ff, rsp_inf_in;

   // memories and their registered read data
   cost_type             row0_mem [ROW_DEPTH];
   cost_type             row1_mem [ROW_DEPTH];
   cost_type             row0_rd_ff, row1_rd_ff;
   logic [EW-1:0]        bp_mem [BP_DEPTH];
   logic [EW-1:0]        bp_rd_ff;
   logic [SW-1:0]        slot_mem [1 << LW];
   logic [SW-1:0]        slot_rd_ff;

   // control strobes and datapath helpers
   logic                 tbl_wr, row_rd, row_wr, bp_rd, bp_wr, slot_rd, slot_wr;
   logic                 clr_cur, clr_run, term_start, rsp_load, rsp_free;
   logic [SW-1:0]        tbl_addr;
   logic signed [15:0]   tbl_rd;
   logic [NVW-1:0]       nv_eff;
   logic [CW-1:0]        cap_eff, t;
   logic [EW-1:0]        cur_addr, prev_addr;
   logic [16:0]          da;
   logic                 last_p, last_o, prev_ok, cur_ok;
   cost_type             prev_cost, cur_cost, nc, wr_cost;
   logic [EW-1:0]        bp_wdata;
   logic signed [16:0]   dvs;
   logic signed [16:0]   dd;
   eng_state_type        pair_next;
   logic [SW-1:0]        pair_o, pair_p;

   // effective register values
   assign nv_eff  = (int'(cfg.num_values) > MAX_VALUES) ? NVW'(MAX_VALUES)
                                                         : NVW'(cfg.num_values);
   assign cap_eff = (int'(cfg.capacity) > MAX_CAPACITY) ? CW'(MAX_CAPACITY)
                                                         : CW'(cfg.capacity);

   // entry addresses
   assign da        = d_ff[16] ? 17'(-d_ff) : 17'(d_ff);
   assign t         = u_ff + da[CW-1:0];
   assign cur_addr  = {p_ff, t};
   assign prev_addr = {o_ff, u_ff};

   assign tbl_rd    = vtab_ff[tbl_addr];
   assign prev_cost = bank_ff ? row0_rd_ff : row1_rd_ff;
   assign cur_cost  = bank_ff ? row1_rd_ff : row0_rd_ff;
   assign prev_ok   = vld_ff[~bank_ff][prev_addr];
   assign cur_ok    = vld_ff[bank_ff][cur_addr];
   assign nc        = sat_cost(ext_cost(prev_cost) + ext_cost(term_cost));

   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;

   // slot pair stepping
   assign last_p = (NVW'(p_ff) + NVW'(1)) == nv_eff;
   assign last_o = (NVW'(o_ff) + NVW'(1)) == nv_eff;

   always_comb begin
      pair_o    = o_ff;
      pair_p    = p_ff + SW'(1);
      pair_next = S_FETCH_O;
      if (last_p) begin
         pair_p = '0;
         if (layer_ff == '0 || last_o) pair_next = S_LAYER_END;
         else pair_o = o_ff + SW'(1);
      end
   end

   // term unit hookup
   assign term_cmd.start     = term_start;
   assign term_cmd.first     = (layer_ff == '0);
   assign term_cmd.add_left  = cfg.bounds_active && (layer_ff == '0);
   assign term_cmd.add_right = cfg.bounds_active && fin_ff;
   assign term_opnd.g        = g_ff;
   assign term_opnd.w        = w_ff;
   assign term_opnd.d        = d_ff;
   assign term_opnd.dv       = dv_ff;
   assign term_opnd.v        = v_ff;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      o_in          = o_ff;
      p_in          = p_ff;
      u_in          = u_ff;
      k_in          = k_ff;
      layer_in      = layer_ff;
      bank_in       = bank_ff;
      fin_in        = fin_ff;
      g_in          = g_ff;
      w_in          = w_ff;
      x_in          = x_ff;
      vo_in         = vo_ff;
      v_in          = v_ff;
      d_in          = d_ff;
      dv_in         = dv_ff;
      e_in          = e_ff;
      best_valid_in = best_valid_ff;
      best_cost_in  = best_cost_ff;
      best_entry_in = best_entry_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_inf_in    = rsp_inf_ff;
      req_chan.ready = 1'b0;
      tbl_wr     = 1'b0;
      tbl_addr   = p_ff;
      row_rd     = 1'b0;
      row_wr     = 1'b0;
      wr_cost    = term_cost;
      bp_rd      = 1'b0;
      bp_wr      = 1'b0;
      bp_wdata   = '0;
      slot_rd    = 1'b0;
      slot_wr    = 1'b0;
      clr_cur    = 1'b0;
      clr_run    = 1'b0;
      term_start = 1'b0;
      rsp_load   = 1'b0;
      dvs        = '0;
      dd         = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               if (req_chan.cmd == CMD_LOAD) begin
                  tbl_wr = (int'(req_chan.value_slot) < MAX_VALUES);
               end else begin
                  g_in    = req_chan.gradient;
                  w_in    = req_chan.switch_weight;
                  x_in    = req_chan.current_value;
                  fin_in  = req_chan.final_layer || (layer_ff == LAST_LAYER);
                  clr_cur = 1'b1;
                  o_in    = '0;
                  p_in    = '0;
                  state_in = (nv_eff == '0) ? S_LAYER_END : S_FETCH_O;
               end
            end
         end
         S_FETCH_O: begin
            tbl_addr = o_ff;
            vo_in    = tbl_rd;
            state_in = S_FETCH_P;
         end
         S_FETCH_P: begin
            tbl_addr = p_ff;
            v_in     = tbl_rd;
            dd       = {tbl_rd[15], tbl_rd} - {x_ff[15], x_ff};
            d_in     = dd;
            dvs      = {tbl_rd[15], tbl_rd} - {vo_ff[15], vo_ff};
            dv_in    = dvs[16] ? 17'(-dvs) : 17'(dvs);
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (da > 17'(cap_eff)) begin
               o_in     = pair_o;
               p_in     = pair_p;
               state_in = pair_next;
            end else begin
               term_start = 1'b1;
               state_in   = S_TERM;
            end
         end
         S_TERM: begin
            if (term_sts.done) begin
               u_in     = '0;
               state_in = (layer_ff == '0) ? S_FIRST_WR : S_RD;
            end
         end
         S_RD: begin
            row_rd   = 1'b1;
            state_in = S_WR;
         end
         S_WR: begin
            // relax one entry, strict compare keeps the earliest
            if (prev_ok && (!cur_ok || nc < cur_cost)) begin
               row_wr   = 1'b1;
               wr_cost  = nc;
               bp_wr    = 1'b1;
               bp_wdata = prev_addr;
               if (fin_ff && (!best_valid_ff || nc < best_cost_ff)) begin
                  best_valid_in = 1'b1;
                  best_cost_in  = nc;
                  best_entry_in = cur_addr;
               end
            end
            if (t == cap_eff) begin
               o_in     = pair_o;
               p_in     = pair_p;
               state_in = pair_next;
            end else begin
               u_in     = u_ff + CW'(1);
               state_in = S_RD;
            end
         end
         S_FIRST_WR: begin
            row_wr   = 1'b1;
            bp_wr    = 1'b1;
            if (fin_ff && (!best_valid_ff || term_cost < best_cost_ff)) begin
               best_valid_in = 1'b1;
               best_cost_in  = term_cost;
               best_entry_in = cur_addr;
            end
            o_in     = pair_o;
            p_in     = pair_p;
            state_in = pair_next;
         end
         S_LAYER_END: begin
            if (!fin_ff) begin
               bank_in  = ~bank_ff;
               layer_in = layer_ff + LW'(1);
               state_in = S_IDLE;
            end else if (!best_valid_ff) begin
               state_in = S_OUT_FAIL;
            end else begin
               k_in     = layer_ff;
               e_in     = best_entry_ff;
               state_in = S_BT_RD;
            end
         end
         S_OUT_FAIL: begin
            if (rsp_free) begin
               rsp_load     = 1'b1;
               rsp_value_in = '0;
               rsp_end_in   = 1'b1;
               rsp_inf_in   = 1'b1;
               clr_run      = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_BT_RD: begin
            bp_rd   = 1'b1;
            slot_wr = 1'b1;
            if (k_ff == '0) state_in = S_OUT_RD;
            else state_in = S_BT_WAIT;
         end
         S_BT_WAIT: begin
            e_in     = bp_rd_ff;
            k_in     = k_ff - LW'(1);
            state_in = S_BT_RD;
         end
         S_OUT_RD: begin
            slot_rd  = 1'b1;
            state_in = S_OUT_PUT;
         end
         S_OUT_PUT: begin
            tbl_addr = slot_rd_ff;
            if (rsp_free) begin
               rsp_load     = 1'b1;
               rsp_value_in = tbl_rd;
               rsp_end_in   = (k_ff == layer_ff);
               rsp_inf_in   = 1'b0;
               if (k_ff == layer_ff) begin
                  clr_run  = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + LW'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (clr_run) begin
         layer_in      = '0;
         best_valid_in = 1'b0;
         best_cost_in  = '0;
         best_entry_in = '0;
      end
   end

   // output register
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.chosen_value = rsp_value_ff;
   assign rsp_chan.run_end      = rsp_end_ff;
   assign rsp_chan.infeasible   = rsp_inf_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         layer_ff      <= '0;
         bank_ff       <= 1'b0;
         best_valid_ff <= 1'b0;
         best_cost_ff  <= '0;
         best_entry_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         vld_ff        <= '0;
         for (int i = 0; i < MAX_VALUES; i++) vtab_ff[i] <= '0;
      end else begin
         state_ff      <= state_in;
         layer_ff      <= layer_in;
         bank_ff       <= bank_in;
         best_valid_ff <= best_valid_in;
         best_cost_ff  <= best_cost_in;
         best_entry_ff <= best_entry_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (clr_run) vld_ff <= '0;
         else if (clr_cur) vld_ff[bank_ff] <= '0;
         else if (row_wr) vld_ff[bank_ff][cur_addr] <= 1'b1;
         if (tbl_wr) vtab_ff[SW'(req_chan.value_slot)] <= req_chan.allowed_value;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      o_ff         <= o_in;
      p_ff         <= p_in;
      u_ff         <= u_in;
      k_ff         <= k_in;
      fin_ff       <= fin_in;
      g_ff         <= g_in;
      w_ff         <= w_in;
      x_ff         <= x_in;
      vo_ff        <= vo_in;
      v_ff         <= v_in;
      d_ff         <= d_in;
      dv_ff        <= dv_in;
      e_ff         <= e_in;
      rsp_value_ff <= rsp_value_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_inf_ff   <= rsp_inf_in;
   end

   // cost row banks, the current bank is bank_ff
   always_ff @(posedge clock) begin
      if (row_wr && !bank_ff) row0_mem[cur_addr] <= wr_cost;
      if (row_rd) row0_rd_ff <= row0_mem[bank_ff ? prev_addr : cur_addr];
   end

   always_ff @(posedge clock) begin
      if (row_wr && bank_ff) row1_mem[cur_addr] <= wr_cost;
      if (row_rd) row1_rd_ff <= row1_mem[bank_ff ? cur_addr : prev_addr];
   end

   // back pointer memory
   always_ff @(posedge clock) begin
      if (bp_wr) bp_mem[{layer_ff, cur_addr}] <= bp_wdata;
      if (bp_rd) bp_rd_ff <= bp_mem[{k_ff, e_ff}];
   end

   // chosen slot stack for first to last output
   always_ff @(posedge clock) begin
      if (slot_wr) slot_mem[k_ff] <= e_ff[EW-1:CW];
      if (slot_rd) slot_rd_ff <= slot_mem[k_ff];
   end

`ifndef NO_ASSERTIONS
   a_done_in_term: assert property (@(posedge clock) disable iff (reset)
      term_sts.done |-> (state_ff == S_TERM))
      else $error("term unit finished outside the term wait");
   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_WR) || (state_ff == S_FIRST_WR)) |-> (t <= cap_eff))
      else $error("relaxation beyond capacity");
   a_layer_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_IDLE) && req_chan.valid && (req_chan.cmd == CMD_LAYER))
      |=> (state_ff != S_IDLE))
      else $error("layer transaction not processed");
   a_bt_has_best: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BT_RD) |-> best_valid_ff)
      else $error("backtrack without a final entry");
`endif

endmodule

// ----- design/capacity_constrained_path_dp.sv -----
// top level of the capacity constrained path block
`timescale 1ns / 1ps

// Picks one allowed value per layer under a total change budget. A load
// transaction writes one value table slot. A layer transaction walks every
// (predecessor slot, candidate slot) pair, with only predecessor slot 0 in
// the first layer: it fetches and checks the pair, computes 1 to 3 cost terms
// in the shared multiplier unit, hands them over and, after the first layer,
// does a read-modify-write of the cost row memory for each capacity step that
// the pair's change leaves. The final layer then backtracks through the back
// pointer memory and emits one result per layer, or one infeasible result.
// There is no clearing pass after reset; the row valid bits clear at once.
module capacity_constrained_path_dp #(
   parameter int MAX_LAYERS   = ccp_pkg::DEF_MAX_LAYERS,
   parameter int MAX_VALUES   = ccp_pkg::DEF_MAX_VALUES,
   parameter int MAX_CAPACITY = ccp_pkg::DEF_MAX_CAPACITY
) (
   input logic       clock,
   input logic       reset,
   ccp_req_if.sink   req_chan,
   ccp_rsp_if.source rsp_chan,
   ccp_csr_if.sink   csr_chan
);
   import ccp_pkg::*;

   cfg_type       cfg;
   term_cmd_type  term_cmd;
   term_opnd_type term_opnd;
   term_sts_type  term_sts;
   cost_type      term_cost;

   // configuration registers
   ccp_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // cost term unit
   ccp_term_unit u_term (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .cmd   (term_cmd),
      .opnd  (term_opnd),
      .sts   (term_sts),
      .cost  (term_cost)
   );

   // relaxation and backtrack engine
   ccp_engine #(
      .MAX_LAYERS   (MAX_LAYERS),
      .MAX_VALUES   (MAX_VALUES),
      .MAX_CAPACITY (MAX_CAPACITY)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .cfg       (cfg),
      .term_cmd  (term_cmd),
      .term_opnd (term_opnd),
      .term_sts  (term_sts),
      .term_cost (term_cost)
   );

endmodule
